/* hdl/bvde_pkg.sv */
package bvde_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 2'd0,
    REG_WIDTH_X  = 2'd1,
    REG_HEIGHT_Y = 2'd2,
    REG_DEPTH_Z  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    MODE_DILATE = 1'b0,
    MODE_ERODE  = 1'b1
  } mode_e;

  typedef struct packed {
    logic voxel_out;
    logic last_voxel;
  } result_t;

  // One 3-tap pass: OR with out-of-volume taps as 0, or AND that zeroes the faces.
  function automatic logic tap3(mode_e m, logic lo_ok, logic hi_ok,
                                logic lo, logic mid, logic hi);
    logic r;
    unique case (m)
      MODE_DILATE: r = mid | (lo_ok & lo) | (hi_ok & hi);
      MODE_ERODE:  r = lo_ok & hi_ok & lo & mid & hi;
    endcase
    return r;
  endfunction

endpackage

/* hdl/bvde_if.sv */
interface bvde_in_if;
  logic valid;
  logic ready;
  logic voxel_in;
  logic drain;

  modport source (output valid, output voxel_in, output drain, input ready);
  modport sink (input valid, input voxel_in, input drain, output ready);
endinterface

interface bvde_out_if;
  logic valid;
  logic ready;
  logic voxel_out;
  logic last_voxel;

  modport source (output valid, output voxel_out, output last_voxel, input ready);
  modport sink (input valid, input voxel_out, input last_voxel, output ready);
endinterface

interface bvde_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bvde_pkg::CFG_IDX_W-1:0]   index;
  logic [bvde_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/bvde_out_fifo.sv */
module bvde_out_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  bvde_pkg::result_t                 push_data_i,
  output logic [bvde_pkg::FIFO_CNT_W-1:0]   cnt_o,
  bvde_out_if.source                        out_o
);

  bvde_pkg::result_t                    entry_q [bvde_pkg::FIFO_DEPTH];
  logic [bvde_pkg::FIFO_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [bvde_pkg::FIFO_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [bvde_pkg::FIFO_CNT_W-1:0]      cnt_q, cnt_d;
  logic                                 pop;

  assign pop              = out_o.valid && out_o.ready;
  assign out_o.valid      = (cnt_q != '0);
  assign out_o.voxel_out  = entry_q[rd_ptr_q].voxel_out;
  assign out_o.last_voxel = entry_q[rd_ptr_q].last_voxel;
  assign cnt_o            = cnt_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + bvde_pkg::FIFO_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + bvde_pkg::FIFO_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + bvde_pkg::FIFO_CNT_W'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - bvde_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/binary_volume_dilate_erode_3x3x3.sv */
// Streaming 3x3x3 cube dilation (mode 0) or erosion (mode 1) of a binary volume given in
// raster order, x fastest. Every accepted transaction that is not an early drain advances
// the stream one voxel; its result appears one plane plus one row plus one voxel later, so
// after the last voxel the user sends drain transactions (or dummy voxels) until the result
// flagged last_voxel comes out, after which the next voxel starts a new volume. A drain sent
// while voxels of the volume are still missing is taken and ignored. The block takes one
// transaction per clock while input ready is high: each voxel does one read-modify-write
// of the row memory (MAX_X words of two rows) in its accept cycle and one of the plane
// memory (two planes) in the next. Its result passes the s1 and s2 stage registers into a
// four-deep output buffer and is offered on the output once written there. Input ready
// drops only when that buffer and the results still in flight fill it. No clearing pass
// is needed after reset. Write the size and mode registers only while the block is idle.
module binary_volume_dilate_erode_3x3x3 #(
  parameter int MAX_X = 256,
  parameter int MAX_Y = 256,
  parameter int MAX_Z = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bvde_cfg_if.sink    cfg_i,
  bvde_in_if.sink     voxel_i,
  bvde_out_if.source  result_o
);

  localparam int XW  = $clog2(MAX_X);
  localparam int YW  = $clog2(MAX_Y);
  localparam int OZW = $clog2(MAX_Z);
  localparam int IZW = $clog2(MAX_Z + 2);
  localparam int XCW = $clog2(MAX_X + 1);
  localparam int YCW = $clog2(MAX_Y + 1);
  localparam int ZCW = $clog2(MAX_Z + 1);
  localparam int AW  = XW + YW;
  localparam int X_RST = (MAX_X < 256) ? MAX_X : 256;
  localparam int Y_RST = (MAX_Y < 256) ? MAX_Y : 256;
  localparam int Z_RST = (MAX_Z < 1024) ? MAX_Z : 1024;
  localparam int CW  = bvde_pkg::FIFO_CNT_W;

  typedef struct packed {
    logic          xr;
    logic [XW-1:0] bx;
    logic [YW-1:0] by;
    logic          bz0;
    logic          y_lo_ok;
    logic          y_hi_ok;
    logic          z_act;
    logic          z_lo_ok;
    logic          z_hi_ok;
    logic          oz0;
    logic          last;
  } s1_t;

  typedef struct packed {
    logic yr;
    logic z_lo_ok;
    logic z_hi_ok;
    logic oz0;
    logic last;
  } s2_t;

  // configuration
  bvde_pkg::mode_e    mode_q, mode_d;
  logic [XCW-1:0]     wx_q, wx_d;
  logic [YCW-1:0]     hy_q, hy_d;
  logic [ZCW-1:0]     dz_q, dz_d;
  logic [8:0]         cfg_v9;
  logic [10:0]        cfg_v11;
  logic [XCW-1:0]     wx_clamp;
  logic [YCW-1:0]     hy_clamp;
  logic [ZCW-1:0]     dz_clamp;

  // stream positions and pass state
  logic [XW-1:0]  in_x_q, in_x_d;
  logic [YW-1:0]  in_y_q, in_y_d;
  logic [IZW-1:0] in_z_q, in_z_d;
  logic [XW-1:0]  xp_x_q, xp_x_d;
  logic [XW-1:0]  yp_x_q, yp_x_d;
  logic [YW-1:0]  yp_y_q, yp_y_d;
  logic           yp_z0_q, yp_z0_d;
  logic [XW-1:0]  out_x_q, out_x_d;
  logic [YW-1:0]  out_y_q, out_y_d;
  logic [OZW-1:0] out_z_q, out_z_d;
  logic [2:0]     win_q, win_d;
  logic           x_run_q, x_run_d;
  logic           y_run_q, y_run_d;
  logic           z_run_q, z_run_d;

  // accept stage
  logic           accept;
  logic           in_live;
  logic           tick;
  logic           x_act, y_act, z_act;
  logic [2:0]     win_new;
  logic           xr;
  logic           xp_x_end, yp_x_end, yp_y_end, in_x_end, in_y_end;
  logic           out_x_end, out_y_end, out_z_end;
  logic           last;
  logic           row_wr_sel;

  // memories and pipeline
  logic [1:0]     row_mem [MAX_X];
  logic [1:0]     plane_mem [2**AW];
  logic [1:0]     row_rd_q;
  logic [1:0]     plane_rd_q;
  logic [AW-1:0]  plane_addr;
  s1_t            s1_q, s1_d;
  logic           s1_v_q;
  s2_t            s2_q, s2_d;
  logic           s2_v_q;
  logic           yr;
  logic           zr;
  logic [CW-1:0]  fifo_cnt;
  logic [CW-1:0]  pending;
  bvde_pkg::result_t push_data;

  // ---------------------------------------------------------------- configuration
  assign cfg_i.ready = 1'b1;
  assign cfg_v9      = cfg_i.data[8:0];
  assign cfg_v11     = cfg_i.data;

  always_comb begin
    if (cfg_v9 < 9'd2) begin
      wx_clamp = XCW'(2);
    end else if (32'(cfg_v9) > MAX_X) begin
      wx_clamp = XCW'(MAX_X);
    end else begin
      wx_clamp = XCW'(cfg_v9);
    end
    if (cfg_v9 < 9'd2) begin
      hy_clamp = YCW'(2);
    end else if (32'(cfg_v9) > MAX_Y) begin
      hy_clamp = YCW'(MAX_Y);
    end else begin
      hy_clamp = YCW'(cfg_v9);
    end
    if (cfg_v11 < 11'd2) begin
      dz_clamp = ZCW'(2);
    end else if (32'(cfg_v11) > MAX_Z) begin
      dz_clamp = ZCW'(MAX_Z);
    end else begin
      dz_clamp = ZCW'(cfg_v11);
    end
  end

  always_comb begin
    mode_d = mode_q;
    wx_d   = wx_q;
    hy_d   = hy_q;
    dz_d   = dz_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (bvde_pkg::cfg_reg_e'(cfg_i.index))
        bvde_pkg::REG_MODE:     mode_d = bvde_pkg::mode_e'(cfg_i.data[0]);
        bvde_pkg::REG_WIDTH_X:  wx_d   = wx_clamp;
        bvde_pkg::REG_HEIGHT_Y: hy_d   = hy_clamp;
        bvde_pkg::REG_DEPTH_Z:  dz_d   = dz_clamp;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bvde_pkg::MODE_DILATE;
      wx_q   <= XCW'(X_RST);
      hy_q   <= YCW'(Y_RST);
      dz_q   <= ZCW'(Z_RST);
    end else begin
      mode_q <= mode_d;
      wx_q   <= wx_d;
      hy_q   <= hy_d;
      dz_q   <= dz_d;
    end
  end

  // ---------------------------------------------------------------- accept stage
  // Hold ready low when a new result could find no room in the output buffer.
  assign pending       = fifo_cnt + CW'(s1_v_q & s1_q.z_act) + CW'(s2_v_q);
  assign voxel_i.ready = (pending < CW'(bvde_pkg::FIFO_DEPTH));
  assign accept        = voxel_i.valid && voxel_i.ready;

  assign in_live = (in_z_q < IZW'(dz_q));
  assign tick    = accept && !(in_live && voxel_i.drain);
  assign x_act   = tick && x_run_q;
  assign y_act   = x_act && y_run_q;
  assign z_act   = y_act && z_run_q;
  assign win_new = {win_q[1:0], in_live & voxel_i.voxel_in};

  assign in_x_end  = (XCW'(in_x_q) + XCW'(1)) >= wx_q;
  assign in_y_end  = (YCW'(in_y_q) + YCW'(1)) >= hy_q;
  assign xp_x_end  = (XCW'(xp_x_q) + XCW'(1)) >= wx_q;
  assign yp_x_end  = (XCW'(yp_x_q) + XCW'(1)) >= wx_q;
  assign yp_y_end  = (YCW'(yp_y_q) + YCW'(1)) >= hy_q;
  assign out_x_end = (XCW'(out_x_q) + XCW'(1)) >= wx_q;
  assign out_y_end = (YCW'(out_y_q) + YCW'(1)) >= hy_q;
  assign out_z_end = (ZCW'(out_z_q) + ZCW'(1)) >= dz_q;

  assign xr   = bvde_pkg::tap3(mode_q, xp_x_q != '0, !xp_x_end,
                               win_new[2], win_new[1], win_new[0]);
  assign last = z_act && out_x_end && out_y_end && out_z_end;

  // The x pass runs one row ahead of the y pass, so its row parity follows from the
  // y pass row; it restarts at even parity on every new plane.
  assign row_wr_sel = y_run_q && !yp_y_end && !yp_y_q[0];

  always_comb begin
    in_x_d  = in_x_q;
    in_y_d  = in_y_q;
    in_z_d  = in_z_q;
    xp_x_d  = xp_x_q;
    yp_x_d  = yp_x_q;
    yp_y_d  = yp_y_q;
    yp_z0_d = yp_z0_q;
    out_x_d = out_x_q;
    out_y_d = out_y_q;
    out_z_d = out_z_q;
    win_d   = win_q;
    x_run_d = x_run_q;
    y_run_d = y_run_q;
    z_run_d = z_run_q;
    if (tick) begin
      win_d   = win_new;
      x_run_d = 1'b1;
      if (in_x_end) begin
        in_x_d = '0;
        if (in_y_end) begin
          in_y_d = '0;
          in_z_d = in_z_q + IZW'(1);
        end else begin
          in_y_d = in_y_q + YW'(1);
        end
      end else begin
        in_x_d = in_x_q + XW'(1);
      end
    end
    if (x_act) begin
      if (xp_x_end) begin
        xp_x_d  = '0;
        y_run_d = 1'b1;
      end else begin
        xp_x_d = xp_x_q + XW'(1);
      end
    end
    if (y_act) begin
      if (yp_x_end) begin
        yp_x_d = '0;
        if (yp_y_end) begin
          yp_y_d  = '0;
          yp_z0_d = !yp_z0_q;
          z_run_d = 1'b1;
        end else begin
          yp_y_d = yp_y_q + YW'(1);
        end
      end else begin
        yp_x_d = yp_x_q + XW'(1);
      end
    end
    if (z_act) begin
      if (out_x_end) begin
        out_x_d = '0;
        if (out_y_end) begin
          out_y_d = '0;
          out_z_d = out_z_q + OZW'(1);
        end else begin
          out_y_d = out_y_q + YW'(1);
        end
      end else begin
        out_x_d = out_x_q + XW'(1);
      end
    end
    // Volume done: restart every position for the next volume.
    if (last) begin
      in_x_d  = '0;
      in_y_d  = '0;
      in_z_d  = '0;
      xp_x_d  = '0;
      yp_x_d  = '0;
      yp_y_d  = '0;
      yp_z0_d = 1'b0;
      out_x_d = '0;
      out_y_d = '0;
      out_z_d = '0;
      win_d   = '0;
      x_run_d = 1'b0;
      y_run_d = 1'b0;
      z_run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_x_q  <= '0;
      in_y_q  <= '0;
      in_z_q  <= '0;
      xp_x_q  <= '0;
      yp_x_q  <= '0;
      yp_y_q  <= '0;
      yp_z0_q <= 1'b0;
      out_x_q <= '0;
      out_y_q <= '0;
      out_z_q <= '0;
      win_q   <= '0;
      x_run_q <= 1'b0;
      y_run_q <= 1'b0;
      z_run_q <= 1'b0;
    end else begin
      in_x_q  <= in_x_d;
      in_y_q  <= in_y_d;
      in_z_q  <= in_z_d;
      xp_x_q  <= xp_x_d;
      yp_x_q  <= yp_x_d;
      yp_y_q  <= yp_y_d;
      yp_z0_q <= yp_z0_d;
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
      out_z_q <= out_z_d;
      win_q   <= win_d;
      x_run_q <= x_run_d;
      y_run_q <= y_run_d;
      z_run_q <= z_run_d;
    end
  end

  // Row memory: word x holds both row parities. The read returns the old word, so the
  // row being overwritten still supplies the upper neighbor.
  always_ff @(posedge clk_i) begin
    if (x_act) begin
      row_mem[xp_x_q][row_wr_sel] <= xr;
    end
    if (y_act) begin
      row_rd_q <= row_mem[yp_x_q];
    end
  end

  always_comb begin
    s1_d.xr      = xr;
    s1_d.bx      = yp_x_q;
    s1_d.by      = yp_y_q;
    s1_d.bz0     = yp_z0_q;
    s1_d.y_lo_ok = (yp_y_q != '0);
    s1_d.y_hi_ok = !yp_y_end;
    s1_d.z_act   = z_act;
    s1_d.z_lo_ok = (out_z_q != '0);
    s1_d.z_hi_ok = !out_z_end;
    s1_d.oz0     = out_z_q[0];
    s1_d.last    = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= y_act;
      s2_v_q <= s1_v_q && s1_q.z_act;
    end
  end

  always_ff @(posedge clk_i) begin
    if (y_act) begin
      s1_q <= s1_d;
    end
    if (s1_v_q) begin
      s2_q <= s2_d;
    end
  end

  // ---------------------------------------------------------------- y pass, plane memory
  assign yr = bvde_pkg::tap3(mode_q, s1_q.y_lo_ok, s1_q.y_hi_ok,
                             row_rd_q[!s1_q.by[0]], row_rd_q[s1_q.by[0]], s1_q.xr);

  assign plane_addr = {s1_q.by, s1_q.bx};

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      plane_mem[plane_addr][s1_q.bz0] <= yr;
    end
    if (s1_v_q && s1_q.z_act) begin
      plane_rd_q <= plane_mem[plane_addr];
    end
  end

  always_comb begin
    s2_d.yr      = yr;
    s2_d.z_lo_ok = s1_q.z_lo_ok;
    s2_d.z_hi_ok = s1_q.z_hi_ok;
    s2_d.oz0     = s1_q.oz0;
    s2_d.last    = s1_q.last;
  end

  // ---------------------------------------------------------------- z pass, output
  assign zr = bvde_pkg::tap3(mode_q, s2_q.z_lo_ok, s2_q.z_hi_ok,
                             plane_rd_q[!s2_q.oz0], plane_rd_q[s2_q.oz0], s2_q.yr);

  assign push_data.voxel_out  = zr;
  assign push_data.last_voxel = s2_q.last;

  bvde_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_v_q),
    .push_data_i (push_data),
    .cnt_o       (fifo_cnt),
    .out_o       (result_o)
  );

`ifndef NO_ASSERTIONS
  a_fifo_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (fifo_cnt < CW'(bvde_pkg::FIFO_DEPTH)))
    else $error("result pushed into a full output buffer");

  a_pass_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (y_run_q |-> x_run_q) and (z_run_q |-> y_run_q))
    else $error("a later pass runs before an earlier one");

  a_s2_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> $past(s1_v_q))
    else $error("z pass item without a y pass item before it");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last |=> (!x_run_q && in_x_q == '0 && in_z_q == '0 && out_z_q == '0))
    else $error("positions not restarted after the last voxel");

  a_last_in_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last |-> (in_z_q != '0))
    else $error("last result before any full plane was taken");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned VOL_MAX_X   = 256;
  localparam int unsigned VOL_MAX_Y   = 256;
  localparam int unsigned VOL_MAX_Z   = 1024;
  localparam int unsigned PHASE_ITEMS = 400;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct {
    int unsigned x;
    int unsigned y;
    int unsigned z;
  } vox_pos_t;

  class morph_scoreboard;
    bvde_pkg::mode_e   mode_q;
    int unsigned       size_x;
    int unsigned       size_y;
    int unsigned       size_z;
    bit [2:0]          window;
    bit                row_mem[2*VOL_MAX_X];
    bit                plane_mem[2*VOL_MAX_X*VOL_MAX_Y];
    vox_pos_t          in_p;
    vox_pos_t          xp_p;
    vox_pos_t          yp_p;
    vox_pos_t          out_p;
    longint unsigned   ticks;
    bvde_pkg::result_t expected_voxels[$];
    int unsigned       failures;

    function new();
      mode_q   = bvde_pkg::MODE_DILATE;
      size_x   = VOL_MAX_X;
      size_y   = VOL_MAX_Y;
      size_z   = VOL_MAX_Z;
      failures = 0;
      restart();
    endfunction

    function void restart();
      in_p   = '{default: 0};
      xp_p   = '{default: 0};
      yp_p   = '{default: 0};
      out_p  = '{default: 0};
      window = '0;
      ticks  = 0;
    endfunction

    function int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(bvde_pkg::cfg_reg_e idx,
                            logic [bvde_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        bvde_pkg::REG_MODE:     mode_q = bvde_pkg::mode_e'(val[0]);
        bvde_pkg::REG_WIDTH_X:  size_x = clamp_size(32'(val[8:0]), VOL_MAX_X);
        bvde_pkg::REG_HEIGHT_Y: size_y = clamp_size(32'(val[8:0]), VOL_MAX_Y);
        bvde_pkg::REG_DEPTH_Z:  size_z = clamp_size(32'(val[10:0]), VOL_MAX_Z);
        default: ;
      endcase
    endfunction

    function bit tap(bit lo_ok, bit hi_ok, bit lo, bit mid, bit hi);
      if (mode_q == bvde_pkg::MODE_DILATE) return mid | (lo_ok & lo) | (hi_ok & hi);
      return lo_ok & hi_ok & lo & mid & hi;
    endfunction

    function vox_pos_t next_pos(vox_pos_t p);
      vox_pos_t n;
      n = p;
      n.x++;
      if (n.x >= size_x) begin
        n.x = 0;
        n.y++;
        if (n.y >= size_y) begin
          n.y = 0;
          n.z++;
        end
      end
      return n;
    endfunction

    function int unsigned plane_idx(int unsigned x, int unsigned y, int unsigned z);
      return (z & 1) * VOL_MAX_X * VOL_MAX_Y + y * VOL_MAX_X + x;
    endfunction

    // Advance the separable x/y/z passes by one stream voxel; an early drain is ignored.
    function bit predict_voxel(bit voxel, bit drain, output bvde_pkg::result_t r);
      bit       v;
      bit       xr;
      bit       yr;
      bit       zr;
      bit       lo;
      bit       mid;
      bit       is_last;
      vox_pos_t a;
      vox_pos_t b;
      r = '0;
      if (in_p.z < size_z) begin
        if (drain) return 0;
        v = voxel;
      end else begin
        v = 1'b0;
      end
      in_p = next_pos(in_p);
      ticks++;
      window = {window[1:0], v};
      if (ticks < 2) return 0;

      a = xp_p;
      xr = tap(a.x > 0, a.x + 1 < size_x, window[2], window[1], window[0]);
      xp_p = next_pos(xp_p);

      if (ticks < size_x + 2) begin
        row_mem[(a.y & 1) * VOL_MAX_X + a.x] = xr;
        return 0;
      end
      b = yp_p;
      mid = row_mem[(b.y & 1) * VOL_MAX_X + b.x];
      lo = row_mem[((b.y + 1) & 1) * VOL_MAX_X + b.x];
      row_mem[(a.y & 1) * VOL_MAX_X + a.x] = xr;
      yr = tap(b.y > 0, b.y + 1 < size_y, lo, mid, xr);
      yp_p = next_pos(yp_p);

      if (ticks < size_x + 2 + size_x * size_y) begin
        plane_mem[plane_idx(b.x, b.y, b.z)] = yr;
        return 0;
      end
      mid = plane_mem[plane_idx(out_p.x, out_p.y, out_p.z)];
      lo = plane_mem[plane_idx(out_p.x, out_p.y, out_p.z + 1)];
      plane_mem[plane_idx(b.x, b.y, b.z)] = yr;
      zr = tap(out_p.z > 0, out_p.z + 1 < size_z, lo, mid, yr);

      is_last = (out_p.x + 1 == size_x) && (out_p.y + 1 == size_y) &&
                (out_p.z + 1 == size_z);
      r.voxel_out  = zr;
      r.last_voxel = is_last;
      if (is_last) restart();
      else out_p = next_pos(out_p);
      return 1;
    endfunction

    function void accept_voxel(bit voxel, bit drain);
      bvde_pkg::result_t r;
      if (predict_voxel(voxel, drain, r)) expected_voxels.push_back(r);
    endfunction

    function void check_result(logic voxel_out, logic last_voxel);
      bvde_pkg::result_t e;
      if (expected_voxels.size() == 0) begin
        $display("%0t: unexpected result voxel_out=%b last_voxel=%b",
                 $time, voxel_out, last_voxel);
        failures++;
        return;
      end
      e = expected_voxels.pop_front();
      if (e.voxel_out !== voxel_out) begin
        $display("%0t: voxel_out mismatch, expected %b actual %b",
                 $time, e.voxel_out, voxel_out);
        failures++;
      end
      if (e.last_voxel !== last_voxel) begin
        $display("%0t: last_voxel mismatch, expected %b actual %b",
                 $time, e.last_voxel, last_voxel);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_voxels.size();
    endfunction

    function bit volume_open();
      return ticks != 0;
    endfunction

    function int unsigned volume_voxels();
      return size_x * size_y * size_z;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  bvde_cfg_if cfg_if ();
  bvde_in_if  voxel_if ();
  bvde_out_if result_if ();

  binary_volume_dilate_erode_3x3x3 #(
    .MAX_X(VOL_MAX_X),
    .MAX_Y(VOL_MAX_Y),
    .MAX_Z(VOL_MAX_Z)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_if),
    .voxel_i (voxel_if),
    .result_o(result_if)
  );

  morph_scoreboard sb;
  int unsigned     snd_idle_pct;
  int unsigned     rcv_stall_pct;
  int unsigned     item_count;
  int unsigned     cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      result_if.ready = ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready)
      sb.check_result(result_if.voxel_out, result_if.last_voxel);
  end

  // All driving tasks start and end at a falling edge.
  task automatic send_voxel(bit voxel, bit drain);
    while ($urandom_range(99) < snd_idle_pct) begin
      voxel_if.valid = 1'b0;
      @(negedge clk_i);
    end
    voxel_if.valid    = 1'b1;
    voxel_if.voxel_in = voxel;
    voxel_if.drain    = drain;
    @(posedge clk_i);
    while (!voxel_if.ready) @(posedge clk_i);
    sb.accept_voxel(voxel, drain);
    @(negedge clk_i);
  endtask

  task automatic program_reg(bvde_pkg::cfg_reg_e idx,
                             logic [bvde_pkg::CFG_DATA_W-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Hold off until every result is out and the pipeline has settled.
  task automatic wait_idle();
    voxel_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic configure(bvde_pkg::mode_e m, logic [bvde_pkg::CFG_DATA_W-1:0] wx,
                           logic [bvde_pkg::CFG_DATA_W-1:0] hy,
                           logic [bvde_pkg::CFG_DATA_W-1:0] dz);
    logic [bvde_pkg::CFG_DATA_W-1:0] mode_word;
    wait_idle();
    mode_word    = bvde_pkg::CFG_DATA_W'($urandom());
    mode_word[0] = m;
    program_reg(bvde_pkg::REG_MODE, mode_word);
    program_reg(bvde_pkg::REG_WIDTH_X, wx);
    program_reg(bvde_pkg::REG_HEIGHT_Y, hy);
    program_reg(bvde_pkg::REG_DEPTH_Z, dz);
    cfg_if.valid = 1'b0;
  endtask

  // Configure, stream one volume with scattered early drains, then send drains or dummy voxels until the last result.
  task automatic run_volume(bvde_pkg::mode_e m, logic [bvde_pkg::CFG_DATA_W-1:0] wx,
                            logic [bvde_pkg::CFG_DATA_W-1:0] hy,
                            logic [bvde_pkg::CFG_DATA_W-1:0] dz,
                            int unsigned fill_pct);
    int unsigned n;
    configure(m, wx, hy, dz);
    if ($urandom_range(3) == 0) send_voxel(1'($urandom_range(1)), 1'b1);
    n = sb.volume_voxels();
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(99) < 4) send_voxel(1'($urandom_range(1)), 1'b1);
      send_voxel($urandom_range(99) < fill_pct, 1'b0);
      item_count++;
    end
    while (sb.volume_open()) begin
      send_voxel(1'($urandom_range(1)), $urandom_range(3) != 0);
      item_count++;
    end
  endtask

  task automatic run_random_volume();
    bvde_pkg::mode_e m;
    int unsigned     fill;
    m = bvde_pkg::mode_e'($urandom_range(1));
    if ($urandom_range(7) == 0) fill = $urandom_range(100);
    else if (m == bvde_pkg::MODE_ERODE) fill = $urandom_range(75, 100);
    else fill = $urandom_range(0, 40);
    run_volume(m, {2'($urandom_range(3)), 9'($urandom_range(0, 9))},
               {2'($urandom_range(3)), 9'($urandom_range(0, 7))},
               11'($urandom_range(0, 6)), fill);
  endtask

  initial begin
    int unsigned snd_pcts[4];
    int unsigned rcv_pcts[4];
    int unsigned phase_start;
    bit [7:0]    pattern;
    snd_pcts          = '{0, 59, 0, 30};
    rcv_pcts          = '{0, 0, 59, 30};
    snd_idle_pct      = 0;
    rcv_stall_pct     = 0;
    item_count        = 0;
    rst_ni            = 1'b0;
    voxel_if.valid    = 1'b0;
    voxel_if.voxel_in = 1'b0;
    voxel_if.drain    = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = bvde_pkg::REG_MODE;
    cfg_if.data       = '0;
    sb = new();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Smallest volume, sizes written below range: one set voxel, early drains,
    // and extra voxels in the drain phase that must not be used.
    configure(bvde_pkg::MODE_DILATE, 11'd1, 11'd0, 11'd1);
    pattern = 8'b0100_0000;
    send_voxel(1'b1, 1'b1);
    for (int k = 0; k < 8; k++) begin
      if (k == 3) send_voxel(1'b0, 1'b1);
      send_voxel(pattern[k], 1'b0);
    end
    while (sb.volume_open()) send_voxel(1'b1, sb.ticks[0]);
    send_voxel(1'b1, 1'b1);

    // Idle and stall phases: wide rows and odd height from dropped upper size bits, then a deeper volume.
    for (int p = 0; p < 4; p++) begin
      snd_idle_pct  = snd_pcts[p];
      rcv_stall_pct = rcv_pcts[p];
      phase_start   = item_count;
      case (p)
        1: run_volume(bvde_pkg::MODE_DILATE, 11'h628, 11'd2, 11'd2, 3);
        2: run_volume(bvde_pkg::MODE_ERODE, 11'd2, 11'h603, 11'd5, 97);
        3: run_volume(bvde_pkg::MODE_DILATE, 11'd2, 11'd2, 11'h009, 8);
        default: ;
      endcase
      while (item_count - phase_start < PHASE_ITEMS) run_random_volume();
    end

    voxel_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
